>>> rtl/core/clcd_pkg.sv
// Shared types, request codes and constant tables for the character LCD
// command sequencer. No dependencies.
package clcd_pkg;

    localparam int MAX_COLUMNS = 40;
    localparam int MaxXfers    = MAX_COLUMNS + 2;
    localparam int StepW       = $clog2(MaxXfers);
    localparam int CfgIdxW     = 1;
    localparam int CfgDataW    = 6;

    localparam logic [3:0] REQ_INIT       = 4'd0;
    localparam logic [3:0] REQ_CLEAR      = 4'd1;
    localparam logic [3:0] REQ_HOME       = 4'd2;
    localparam logic [3:0] REQ_DISP_ON    = 4'd3;
    localparam logic [3:0] REQ_DISP_OFF   = 4'd4;
    localparam logic [3:0] REQ_CURS_ON    = 4'd5;
    localparam logic [3:0] REQ_CURS_OFF   = 4'd6;
    localparam logic [3:0] REQ_BLINK_ON   = 4'd7;
    localparam logic [3:0] REQ_BLINK_OFF  = 4'd8;
    localparam logic [3:0] REQ_CLEAR_LINE = 4'd9;
    localparam logic [3:0] REQ_CHAR       = 4'd10;
    localparam logic [3:0] REQ_COMMAND    = 4'd11;
    localparam logic [3:0] REQ_SET_CURSOR = 4'd12;

    localparam logic [CfgIdxW-1:0] CFG_ROWS    = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_COLUMNS = 1'd1;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] CMD_FUNCTION = 8'h28;
    localparam logic [7:0] CTRL_DEFAULT = 8'h0C;
    localparam logic [7:0] BIT_DISPLAY  = 8'h04;
    localparam logic [7:0] BIT_CURSOR   = 8'h02;
    localparam logic [7:0] BIT_BLINK    = 8'h01;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [13:0] WAIT_POWER_UP = 14'd15000;
    localparam logic [12:0] WAIT_CMD      = 13'd50;
    localparam logic [12:0] WAIT_LONG     = 13'd2000;

    typedef struct packed {
        logic [7:0]  value;
        logic        reg_select;
        logic        nibble_only;
        logic [13:0] pre_wait;
        logic [12:0] post_wait;
        logic        last;
    } t_xfer;

    typedef struct packed {
        logic             load_req;
        logic             load_out;
        logic [StepW-1:0] step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic none;
        logic last;
    } t_dp_status;

    function automatic logic [7:0] line_base(input logic [1:0] row);
        logic [7:0] base;
        unique case (row)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'hC0;
            2'd2:    base = 8'h94;
            default: base = 8'hD4;
        endcase
        return base;
    endfunction

    function automatic t_xfer init_xfer(input logic [2:0] step);
        t_xfer x;
        x = '0;
        unique case (step)
            3'd0: begin
                x.value = 8'h03; x.nibble_only = 1'b1;
                x.pre_wait = WAIT_POWER_UP; x.post_wait = 13'd5000;
            end
            3'd1: begin
                x.value = 8'h03; x.nibble_only = 1'b1; x.post_wait = 13'd110;
            end
            3'd2: begin
                x.value = 8'h03; x.nibble_only = 1'b1; x.post_wait = 13'd110;
            end
            3'd3: begin
                x.value = 8'h02; x.nibble_only = 1'b1; x.post_wait = 13'd100;
            end
            3'd4: begin
                x.value = CMD_FUNCTION; x.post_wait = 13'd100;
            end
            3'd5: begin
                x.value = CMD_ENTRY; x.post_wait = WAIT_CMD;
            end
            3'd6: begin
                x.value = CTRL_DEFAULT; x.post_wait = WAIT_CMD;
            end
            default: begin
                x.value = CMD_CLEAR; x.post_wait = WAIT_LONG;
            end
        endcase
        return x;
    endfunction

endpackage

>>> rtl/core/clcd_dp.sv
// Datapath of the character LCD sequencer: configuration, request and shadow
// registers, transfer generation and the output payload register. Uses clcd_pkg.
module clcd_dp
    import clcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic [3:0]          i_req_type,
    input  logic [7:0]          i_char_or_cmd,
    input  logic [5:0]          i_column,
    input  logic [2:0]          i_row,
    input  t_ctrl_cmd           i_cmd,
    output t_dp_status          o_status,
    output t_xfer               o_xfer
);

    logic [2:0]       r_rows;
    logic [5:0]       r_cols;
    logic [7:0]       r_shadow;
    logic [7:0]       n_shadow;
    logic [3:0]       r_req;
    logic [7:0]       r_byte;
    logic [5:0]       r_col;
    logic [2:0]       r_row;
    t_xfer            r_xfer;
    t_xfer            n_xfer;
    logic [5:0]       eff_cols;
    logic [2:0]       eff_rows;
    logic [5:0]       cur_x;
    logic [2:0]       cur_y;
    logic [7:0]       cursor_byte;
    logic [StepW-1:0] count;
    logic             last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= 3'd2;
            r_cols   <= 6'd16;
            r_shadow <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_ROWS) begin
                r_rows <= i_cfg_data[2:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_COLUMNS) begin
                r_cols <= i_cfg_data;
            end
            r_shadow <= n_shadow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req  <= i_req_type;
            r_byte <= i_char_or_cmd;
            r_col  <= i_column;
            r_row  <= i_row;
        end
        if (i_cmd.load_out) begin
            r_xfer <= n_xfer;
        end
    end

    always_comb begin
        n_shadow = r_shadow;
        if (i_cmd.load_req) begin
            unique case (i_req_type)
                REQ_INIT:      n_shadow = CTRL_DEFAULT;
                REQ_DISP_ON:   n_shadow = r_shadow | BIT_DISPLAY;
                REQ_DISP_OFF:  n_shadow = r_shadow & ~BIT_DISPLAY;
                REQ_CURS_ON:   n_shadow = r_shadow | BIT_CURSOR;
                REQ_CURS_OFF:  n_shadow = r_shadow & ~BIT_CURSOR;
                REQ_BLINK_ON:  n_shadow = r_shadow | BIT_BLINK;
                REQ_BLINK_OFF: n_shadow = r_shadow & ~BIT_BLINK;
                default:       n_shadow = r_shadow;
            endcase
        end
    end

    always_comb begin
        if (r_cols == 6'd0) begin
            eff_cols = 6'd1;
        end else if (r_cols > 6'(MAX_COLUMNS)) begin
            eff_cols = 6'(MAX_COLUMNS);
        end else begin
            eff_cols = r_cols;
        end
        if (r_rows == 3'd0) begin
            eff_rows = 3'd1;
        end else if (r_rows > 3'd4) begin
            eff_rows = 3'd4;
        end else begin
            eff_rows = r_rows;
        end
        cur_x = '0;
        if (r_req == REQ_SET_CURSOR) begin
            cur_x = (r_col >= eff_cols) ? eff_cols - 6'd1 : r_col;
        end
        cur_y       = (r_row >= eff_rows) ? eff_rows - 3'd1 : r_row;
        cursor_byte = line_base(cur_y[1:0]) + {2'b00, cur_x};
    end

    always_comb begin
        unique case (r_req)
            REQ_INIT:       count = StepW'(8);
            REQ_CLEAR_LINE: count = StepW'(eff_cols) + StepW'(2);
            REQ_CLEAR, REQ_HOME, REQ_DISP_ON, REQ_DISP_OFF, REQ_CURS_ON,
            REQ_CURS_OFF, REQ_BLINK_ON, REQ_BLINK_OFF, REQ_CHAR, REQ_COMMAND,
            REQ_SET_CURSOR: count = StepW'(1);
            default:        count = '0;
        endcase
        last = (i_cmd.step == count - StepW'(1));
    end

    always_comb begin
        n_xfer           = '0;
        n_xfer.post_wait = WAIT_CMD;
        unique case (r_req)
            REQ_INIT:  n_xfer = init_xfer(i_cmd.step[2:0]);
            REQ_CLEAR: begin
                n_xfer.value = CMD_CLEAR; n_xfer.post_wait = WAIT_LONG;
            end
            REQ_HOME: begin
                n_xfer.value = CMD_HOME; n_xfer.post_wait = WAIT_LONG;
            end
            REQ_DISP_ON, REQ_DISP_OFF, REQ_CURS_ON, REQ_CURS_OFF,
            REQ_BLINK_ON, REQ_BLINK_OFF: n_xfer.value = r_shadow;
            REQ_CLEAR_LINE: begin
                if (i_cmd.step == '0 || last) begin
                    n_xfer.value = cursor_byte;
                end else begin
                    n_xfer.value      = CHAR_SPACE;
                    n_xfer.reg_select = 1'b1;
                end
            end
            REQ_CHAR: begin
                n_xfer.value = r_byte; n_xfer.reg_select = 1'b1;
            end
            REQ_COMMAND:    n_xfer.value = r_byte;
            REQ_SET_CURSOR: n_xfer.value = cursor_byte;
            default:        n_xfer.value = '0;
        endcase
        n_xfer.last = last;
    end

    assign o_status.none = (count == '0);
    assign o_status.last = last;
    assign o_xfer        = r_xfer;

endmodule

>>> rtl/core/clcd_ctrl.sv
// Controller of the character LCD sequencer: the idle/run state machine, the
// transfer step counter and the output valid flag. Uses clcd_pkg.
module clcd_ctrl
    import clcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [StepW-1:0] r_step;
    logic [StepW-1:0] n_step;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             load_req;
    logic             load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        load_req = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    load_req = 1'b1;
                    n_step   = '0;
                    n_state  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.none) begin
                    n_state = ST_IDLE;
                end else if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_step   = r_step + StepW'(1);
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
        endcase
        n_out_valid = load_out ? 1'b1 : (r_out_valid && !i_ready);
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_cmd.load_req = load_req;
    assign o_cmd.load_out = load_out;
    assign o_cmd.step     = r_step;

endmodule

>>> rtl/core/char_lcd_command_sequencer.sv
// Top level of the character LCD command sequencer: joins the controller and
// the datapath. Uses clcd_pkg, clcd_ctrl and clcd_dp.
//
//   Channel   Handshake             Payload
//   request   i_valid / o_ready     i_req_type, i_char_or_cmd, i_column, i_row
//   transfer  o_valid / i_ready     o_xfer_value .. o_last_of_run
//   config    i_cfg_we              i_cfg_index, i_cfg_data
//
// A request is accepted while idle and then gives one transfer per cycle from
// the step counter while the sink takes them; a line clear on a 40-column
// display gives 42 transfers, and an unused request code gives no transfer
// but still passes through the run state before the block is ready again.
// The transfer register stalls the step counter while a transfer waits.
// Reset is synchronous; it restores 2 rows, 16 columns and a zero shadow.
module char_lcd_command_sequencer
    import clcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [3:0]          i_req_type,
    input  logic [7:0]          i_char_or_cmd,
    input  logic [5:0]          i_column,
    input  logic [2:0]          i_row,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_xfer_value,
    output logic                o_reg_select,
    output logic                o_nibble_only,
    output logic [13:0]         o_pre_wait_us,
    output logic [12:0]         o_post_wait_us,
    output logic                o_last_of_run
);

    t_ctrl_cmd  cmd;
    t_dp_status status;
    t_xfer      xfer;

    clcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    clcd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_char_or_cmd (i_char_or_cmd),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_xfer        (xfer)
    );

    assign o_xfer_value   = xfer.value;
    assign o_reg_select   = xfer.reg_select;
    assign o_nibble_only  = xfer.nibble_only;
    assign o_pre_wait_us  = xfer.pre_wait;
    assign o_post_wait_us = xfer.post_wait;
    assign o_last_of_run  = xfer.last;

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("sequencer ready in the cycle after accepting an item");

    a_step_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step <= StepW'(MaxXfers))
        else $error("transfer step beyond the longest request");

    a_idle_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_out && status.last) |=> (o_ready && o_valid && o_last_of_run))
        else $error("last transfer loaded without returning to idle");

    a_no_load_when_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !cmd.load_out)
        else $error("transfer register overwritten while stalled");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the character LCD command sequencer.
// Predicts every bus transfer of each accepted request and checks the
// transfer stream in order. Depends on clcd_pkg and char_lcd_command_sequencer.
`timescale 1ns / 1ps

module tb;
    import clcd_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PERCENT = 20;
    localparam int REPORT_MAX   = 10;
    localparam int SWEEP_ITEMS  = 38;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_we       = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index    = '0;
    logic [CfgDataW-1:0] i_cfg_data     = '0;
    logic                i_valid        = 1'b0;
    logic                o_ready;
    logic [3:0]          i_req_type     = '0;
    logic [7:0]          i_char_or_cmd  = '0;
    logic [5:0]          i_column       = '0;
    logic [2:0]          i_row          = '0;
    logic                o_valid;
    logic                i_ready        = 1'b0;
    logic [7:0]          o_xfer_value;
    logic                o_reg_select;
    logic                o_nibble_only;
    logic [13:0]         o_pre_wait_us;
    logic [12:0]         o_post_wait_us;
    logic                o_last_of_run;

    t_xfer      xfer_expected[$];
    logic [2:0] rows_reg    = 3'd2;
    logic [5:0] cols_reg    = 6'd16;
    logic [7:0] ctrl_shadow = 8'h00;

    int cycle_count      = 0;
    int requests_sent    = 0;
    int xfers_checked    = 0;
    int mismatch_count   = 0;
    int settings_used    = 0;
    int sink_hold_cycles = 0;
    bit src_idle_en      = 1'b1;
    bit sink_idle_en     = 1'b1;

    char_lcd_command_sequencer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_char_or_cmd  (i_char_or_cmd),
        .i_column       (i_column),
        .i_row          (i_row),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_xfer_value   (o_xfer_value),
        .o_reg_select   (o_reg_select),
        .o_nibble_only  (o_nibble_only),
        .o_pre_wait_us  (o_pre_wait_us),
        .o_post_wait_us (o_post_wait_us),
        .o_last_of_run  (o_last_of_run)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d transfers outstanding.",
                     cycle_count, xfer_expected.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Transfer sink: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            i_ready <= 1'b0;
            sink_hold_cycles <= sink_hold_cycles - 1;
        end else if (sink_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_xfer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (xfer_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("Unexpected transfer at cycle %0d: value %h rs %b nib %b",
                             cycle_count, o_xfer_value, o_reg_select, o_nibble_only);
            end else begin
                want = xfer_expected.pop_front();
                xfers_checked++;
                if (o_xfer_value !== want.value || o_reg_select !== want.reg_select ||
                    o_nibble_only !== want.nibble_only || o_pre_wait_us !== want.pre_wait ||
                    o_post_wait_us !== want.post_wait || o_last_of_run !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("Mismatch at cycle %0d, transfer %0d:", cycle_count,
                                 xfers_checked);
                        $display("  expected value %h rs %b nib %b pre %0d post %0d last %b",
                                 want.value, want.reg_select, want.nibble_only,
                                 want.pre_wait, want.post_wait, want.last);
                        $display("  actual   value %h rs %b nib %b pre %0d post %0d last %b",
                                 o_xfer_value, o_reg_select, o_nibble_only,
                                 o_pre_wait_us, o_post_wait_us, o_last_of_run);
                    end
                end
            end
        end
    end

    function automatic int effective_columns();
        int c;
        c = cols_reg;
        if (c < 1) c = 1;
        if (c > MAX_COLUMNS) c = MAX_COLUMNS;
        return c;
    endfunction

    function automatic logic [7:0] cursor_address(input logic [5:0] col, input logic [2:0] row);
        int r;
        int x;
        int y;
        logic [7:0] base;
        r = rows_reg;
        if (r < 1) r = 1;
        if (r > 4) r = 4;
        x = col;
        y = row;
        if (x >= effective_columns()) x = effective_columns() - 1;
        if (y >= r) y = r - 1;
        case (y)
            0: base = 8'h80;
            1: base = 8'hC0;
            2: base = 8'h94;
            default: base = 8'hD4;
        endcase
        return base + 8'(x);
    endfunction

    function automatic void add_xfer(input logic [7:0] value, input logic rs, input logic nib,
                                     input logic [13:0] pre, input logic [12:0] post,
                                     input logic last);
        t_xfer x;
        x.value       = value;
        x.reg_select  = rs;
        x.nibble_only = nib;
        x.pre_wait    = pre;
        x.post_wait   = post;
        x.last        = last;
        xfer_expected.push_back(x);
    endfunction

    function automatic void predict_transfers(input logic [3:0] req, input logic [7:0] data,
                                              input logic [5:0] col, input logic [2:0] row);
        logic [7:0] addr;
        int n;
        case (req)
            REQ_INIT: begin
                add_xfer(8'h03, 1'b0, 1'b1, WAIT_POWER_UP, 13'd5000, 1'b0);
                add_xfer(8'h03, 1'b0, 1'b1, 14'd0, 13'd110, 1'b0);
                add_xfer(8'h03, 1'b0, 1'b1, 14'd0, 13'd110, 1'b0);
                add_xfer(8'h02, 1'b0, 1'b1, 14'd0, 13'd100, 1'b0);
                add_xfer(CMD_FUNCTION, 1'b0, 1'b0, 14'd0, 13'd100, 1'b0);
                add_xfer(CMD_ENTRY, 1'b0, 1'b0, 14'd0, WAIT_CMD, 1'b0);
                ctrl_shadow = CTRL_DEFAULT;
                add_xfer(ctrl_shadow, 1'b0, 1'b0, 14'd0, WAIT_CMD, 1'b0);
                add_xfer(CMD_CLEAR, 1'b0, 1'b0, 14'd0, WAIT_LONG, 1'b1);
            end
            REQ_CLEAR: add_xfer(CMD_CLEAR, 1'b0, 1'b0, 14'd0, WAIT_LONG, 1'b1);
            REQ_HOME:  add_xfer(CMD_HOME, 1'b0, 1'b0, 14'd0, WAIT_LONG, 1'b1);
            REQ_DISP_ON, REQ_DISP_OFF, REQ_CURS_ON, REQ_CURS_OFF,
            REQ_BLINK_ON, REQ_BLINK_OFF: begin
                case (req)
                    REQ_DISP_ON:   ctrl_shadow = ctrl_shadow | BIT_DISPLAY;
                    REQ_DISP_OFF:  ctrl_shadow = ctrl_shadow & ~BIT_DISPLAY;
                    REQ_CURS_ON:   ctrl_shadow = ctrl_shadow | BIT_CURSOR;
                    REQ_CURS_OFF:  ctrl_shadow = ctrl_shadow & ~BIT_CURSOR;
                    REQ_BLINK_ON:  ctrl_shadow = ctrl_shadow | BIT_BLINK;
                    default:       ctrl_shadow = ctrl_shadow & ~BIT_BLINK;
                endcase
                add_xfer(ctrl_shadow, 1'b0, 1'b0, 14'd0, WAIT_CMD, 1'b1);
            end
            REQ_CLEAR_LINE: begin
                addr = cursor_address(6'd0, row);
                n = effective_columns();
                add_xfer(addr, 1'b0, 1'b0, 14'd0, WAIT_CMD, 1'b0);
                for (int i = 0; i < n; i++)
                    add_xfer(CHAR_SPACE, 1'b1, 1'b0, 14'd0, WAIT_CMD, 1'b0);
                add_xfer(addr, 1'b0, 1'b0, 14'd0, WAIT_CMD, 1'b1);
            end
            REQ_CHAR:       add_xfer(data, 1'b1, 1'b0, 14'd0, WAIT_CMD, 1'b1);
            REQ_COMMAND:    add_xfer(data, 1'b0, 1'b0, 14'd0, WAIT_CMD, 1'b1);
            REQ_SET_CURSOR: add_xfer(cursor_address(col, row), 1'b0, 1'b0, 14'd0, WAIT_CMD,
                                     1'b1);
            default: ;
        endcase
    endfunction

    task automatic send_request(input logic [3:0] req, input logic [7:0] data,
                                input logic [5:0] col, input logic [2:0] row);
        if (src_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_char_or_cmd <= data;
        i_column      <= col;
        i_row         <= row;
        do @(posedge i_clk); while (!o_ready);
        predict_transfers(req, data, col, row);
        requests_sent++;
    endtask

    task automatic send_random_request();
        int pick;
        logic [3:0] req;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            req = REQ_CHAR;
        else if (pick < 42)
            req = REQ_COMMAND;
        else if (pick < 60)
            req = REQ_SET_CURSOR;
        else if (pick < 68)
            req = REQ_CLEAR_LINE;
        else if (pick < 84)
            req = 4'($urandom_range(REQ_DISP_ON, REQ_BLINK_OFF));
        else if (pick < 90)
            req = ($urandom_range(0, 1) != 0) ? REQ_CLEAR : REQ_HOME;
        else if (pick < 94)
            req = REQ_INIT;
        else
            req = REQ_SET_CURSOR + 4'($urandom_range(1, 3));
        send_request(req, 8'($urandom), 6'($urandom), 3'($urandom));
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (xfer_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ROWS)
            rows_reg = data[2:0];
        else
            cols_reg = data;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [2:0] rows, input logic [5:0] cols);
        write_reg(CFG_ROWS, {3'($urandom), rows});
        write_reg(CFG_COLUMNS, cols);
        settings_used++;
    endtask

    // Reset geometry (2 x 16); the control bits start from a zero shadow.
    task automatic test_directed();
        send_request(REQ_DISP_ON, 8'h00, 6'd0, 3'd0);
        send_request(REQ_CURS_ON, 8'h00, 6'd0, 3'd0);
        send_request(REQ_BLINK_ON, 8'h00, 6'd0, 3'd0);
        send_request(REQ_DISP_OFF, 8'h00, 6'd0, 3'd0);
        send_request(REQ_CURS_OFF, 8'h00, 6'd0, 3'd0);
        send_request(REQ_BLINK_OFF, 8'h00, 6'd0, 3'd0);
        send_request(REQ_INIT, 8'h00, 6'd0, 3'd0);
        send_request(REQ_CLEAR, 8'h00, 6'd0, 3'd0);
        send_request(REQ_HOME, 8'h00, 6'd0, 3'd0);
        send_request(REQ_CHAR, 8'h00, 6'd0, 3'd0);
        send_request(REQ_CHAR, 8'hFF, 6'd63, 3'd7);
        send_request(REQ_COMMAND, 8'h00, 6'd0, 3'd0);
        send_request(REQ_COMMAND, 8'hFF, 6'd0, 3'd0);
        send_request(REQ_COMMAND, 8'hA5, 6'd0, 3'd0);
        send_request(REQ_CHAR, 8'h5A, 6'd0, 3'd0);
        send_request(REQ_SET_CURSOR, 8'h00, 6'd0, 3'd0);
        send_request(REQ_SET_CURSOR, 8'h00, 6'd63, 3'd7);
        send_request(REQ_SET_CURSOR, 8'h00, 6'd15, 3'd1);
        send_request(REQ_SET_CURSOR, 8'h00, 6'd16, 3'd2);
        send_request(REQ_CLEAR_LINE, 8'h00, 6'd0, 3'd0);
        send_request(REQ_CLEAR_LINE, 8'h00, 6'd63, 3'd7);
        send_request(REQ_SET_CURSOR + 4'd1, 8'hFF, 6'd63, 3'd7);
        send_request(REQ_SET_CURSOR + 4'd3, 8'h00, 6'd0, 3'd0);
        send_request(REQ_DISP_ON, 8'h00, 6'd0, 3'd0);
        wait_until_drained();
    endtask

    // Extreme, out-of-range and ordinary display geometries, then a random one.
    task automatic test_geometry_sweep();
        logic [2:0] rows_set[8] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd3, 3'd2, 3'd5, 3'd0};
        logic [5:0] cols_set[8] = '{6'd40, 6'd1, 6'd0, 6'd63, 6'd20, 6'd8, 6'd39, 6'd0};
        for (int p = 0; p < 8; p++) begin
            if (p == 7)
                set_geometry(3'($urandom_range(1, 4)), 6'($urandom_range(1, 40)));
            else
                set_geometry(rows_set[p], cols_set[p]);
            repeat (SWEEP_ITEMS) send_random_request();
            wait_until_drained();
        end
    endtask

    // The sink holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        set_geometry(3'd4, 6'd40);
        sink_hold_cycles = 400;
        for (int i = 0; i < 30; i++) begin
            if (i % 6 == 0)
                send_request(REQ_CLEAR_LINE, 8'h00, 6'd0, 3'($urandom));
            else
                send_request(REQ_CHAR, 8'($urandom), 6'd0, 3'd0);
        end
        wait_until_drained();
    endtask

    task automatic test_no_idle();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (60) send_random_request();
        wait_until_drained();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_geometry_sweep();
        test_backpressure();
        test_no_idle();
        wait_until_drained();
        $display("Sent %0d requests over %0d display geometries; checked %0d transfers.",
                 requests_sent, settings_used, xfers_checked);
        $display("Mismatching or unexpected transfers: %0d.", mismatch_count);
        if (mismatch_count == 0 && xfer_expected.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
